>>> rtl/rtc_fields_to_epoch_seconds_top_macros.svh
// Assertion macros for the clock-to-epoch conversion RTL.
`ifndef RTC_FIELDS_TO_EPOCH_SECONDS_TOP_MACROS_SVH
`define RTC_FIELDS_TO_EPOCH_SECONDS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of i_clk, off while reset is asserted.
`define RTCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked on every rising edge of i_clk, reset included.
`define RTCF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RTCF_ASSERT(lbl, prop, msg)
`define RTCF_ASSERT_NR(lbl, prop, msg)
`endif

`endif

>>> rtl/rtcf_pkg.sv
// Shared types, constants and tables for the clock-to-epoch conversion.
package rtcf_pkg;

    // Number of register stages between input and output.
    localparam int unsigned NUM_STAGES = 7;

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BCD_MODE    = 8'd0,
        REG_HOUR24_MODE = 8'd1
    } t_cfg_reg;

    // Datapath widths.
    localparam int unsigned YEAR_W  = 15;  // century*100 + year, at most 25755
    localparam int unsigned Q100_W  = 9;   // year / 100
    localparam int unsigned Y365_W  = 24;  // year * 365
    localparam int unsigned TOD_W   = 20;  // seconds within the (unchecked) day
    localparam int unsigned MDAY_W  = 10;  // month offset plus day of month
    localparam int unsigned DAYS_W  = 25;  // signed day count from the epoch
    localparam int unsigned TOTAL_W = 42;  // signed exact second count

    // Division by 100 as a multiply and shift; exact for inputs below 43690.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    // Day number of 1970-01-01 plus the 365 and 1 taken out of the day sum.
    localparam logic [19:0] EPOCH_BIAS = 20'd719528;

    localparam logic signed [17:0] DAY_SECS = 18'sd86400;

    // Days in the year before the first of each month (non-leap year).
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Decoded register fields after the first stage.
    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic [7:0] century;
        logic       month_err;
    } t_fields;

    // Day count and time of day leaving the day counter.
    typedef struct packed {
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
        logic                     err;
    } t_days;

endpackage

>>> rtl/rtcf_decode.sv
// First stage: BCD or binary decode, 12-hour conversion and month clamp.
module rtcf_decode (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_bcd_mode,
    input  logic              i_hour24_mode,
    input  logic [7:0]        i_raw_second,
    input  logic [7:0]        i_raw_minute,
    input  logic [7:0]        i_raw_hour,
    input  logic [7:0]        i_raw_day,
    input  logic [7:0]        i_raw_month,
    input  logic [7:0]        i_raw_year,
    input  logic [7:0]        i_raw_century,
    output rtcf_pkg::t_fields o_fields
);

    // Decimal value of a byte: high nibble times ten plus low nibble in BCD mode.
    function automatic logic [7:0] bcd_dec(input logic [7:0] b, input logic bcd);
        logic [7:0] v;
        if (bcd) begin
            v = 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
        end else begin
            v = b;
        end
        return v;
    endfunction

    rtcf_pkg::t_fields n_fields;
    rtcf_pkg::t_fields r_fields;
    logic [7:0]        w_hour12;
    logic [7:0]        w_month;

    // Decode every field; the PM bit is dropped before a 12-hour decode.
    always_comb begin
        n_fields.second  = bcd_dec(i_raw_second, i_bcd_mode);
        n_fields.minute  = bcd_dec(i_raw_minute, i_bcd_mode);
        n_fields.day     = bcd_dec(i_raw_day, i_bcd_mode);
        n_fields.year    = bcd_dec(i_raw_year, i_bcd_mode);
        n_fields.century = bcd_dec(i_raw_century, i_bcd_mode);
        w_hour12 = bcd_dec({1'b0, i_raw_hour[6:0]}, i_bcd_mode);
        w_month  = bcd_dec(i_raw_month, i_bcd_mode);

        // Twelve o'clock is hour 0 in the morning and stays 12 in the afternoon.
        if (i_hour24_mode) begin
            n_fields.hour = bcd_dec(i_raw_hour, i_bcd_mode);
        end else if (i_raw_hour[7]) begin
            n_fields.hour = (w_hour12 == 8'd12) ? 8'd12 : w_hour12 + 8'd12;
        end else begin
            n_fields.hour = (w_hour12 == 8'd12) ? 8'd0 : w_hour12;
        end

        // Months outside one to twelve are pulled to the nearest end and flagged.
        if (w_month == 8'd0) begin
            n_fields.month     = 4'd1;
            n_fields.month_err = 1'b1;
        end else if (w_month > 8'd12) begin
            n_fields.month     = 4'd12;
            n_fields.month_err = 1'b1;
        end else begin
            n_fields.month     = w_month[3:0];
            n_fields.month_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fields <= n_fields;
        end
    end

    assign o_fields = r_fields;

endmodule

>>> rtl/rtcf_days.sv
// Stages two to five: full year, leap rule and signed day count from 1970.
module rtcf_days (
    input  logic              i_clk,
    input  logic [3:0]        i_adv,
    input  rtcf_pkg::t_fields i_fields,
    output rtcf_pkg::t_days   o_days
);

    localparam int unsigned YW = rtcf_pkg::YEAR_W;
    localparam int unsigned PW = YW + 13;

    // Stage two registers.
    logic [YW-1:0]              r2_year;
    logic [rtcf_pkg::TOD_W-1:0] r2_tod;
    logic [7:0]                 r2_day;
    logic [3:0]                 r2_month;
    logic                       r2_err;

    // Stage three registers.
    logic [YW-1:0]                  r3_year;
    logic [rtcf_pkg::Q100_W-1:0]    r3_q100;
    logic [rtcf_pkg::Y365_W-1:0]    r3_y365;
    logic [rtcf_pkg::TOD_W-1:0]     r3_tod;
    logic [7:0]                     r3_day;
    logic [3:0]                     r3_month;
    logic                           r3_err;

    // Stage four registers.
    logic [rtcf_pkg::Y365_W-1:0]    r4_y365;
    logic [YW-3:0]                  r4_d4;
    logic [rtcf_pkg::Q100_W-1:0]    r4_d100;
    logic [rtcf_pkg::Q100_W-3:0]    r4_d400;
    logic [rtcf_pkg::MDAY_W-1:0]    r4_mday;
    logic [rtcf_pkg::TOD_W-1:0]     r4_tod;
    logic                           r4_err;

    // Stage five registers.
    rtcf_pkg::t_days r5_days;

    logic [PW-1:0]                  w_prod100;
    logic [YW-1:0]                  w_rem_full;
    logic [6:0]                     w_rem100;
    logic                           w_year0;
    logic                           w_leap;
    logic [YW-3:0]                  w_q4;
    logic [rtcf_pkg::Q100_W-3:0]    w_q400;
    logic [rtcf_pkg::Q100_W-1:0]    n_d100;
    logic [YW-3:0]                  n_d4;
    logic [rtcf_pkg::Q100_W-3:0]    n_d400;
    logic [rtcf_pkg::MDAY_W-1:0]    n_mday;
    logic [rtcf_pkg::DAYS_W-1:0]    n_days;

    // Stage two: full year and seconds within the day.
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r2_year  <= YW'(i_fields.century) * YW'(100) + YW'(i_fields.year);
            r2_tod   <= rtcf_pkg::TOD_W'(i_fields.hour) * rtcf_pkg::TOD_W'(3600)
                      + rtcf_pkg::TOD_W'(i_fields.minute) * rtcf_pkg::TOD_W'(60)
                      + rtcf_pkg::TOD_W'(i_fields.second);
            r2_day   <= i_fields.day;
            r2_month <= i_fields.month;
            r2_err   <= i_fields.month_err;
        end
    end

    // Stage three: year divided by 100 through the reciprocal, and year times 365.
    assign w_prod100 = PW'(r2_year) * PW'(rtcf_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r3_year  <= r2_year;
            r3_q100  <= w_prod100[rtcf_pkg::RECIP_SHIFT +: rtcf_pkg::Q100_W];
            r3_y365  <= rtcf_pkg::Y365_W'(r2_year) * rtcf_pkg::Y365_W'(365);
            r3_tod   <= r2_tod;
            r3_day   <= r2_day;
            r3_month <= r2_month;
            r3_err   <= r2_err;
        end
    end

    // Stage four: leap rule and the (year - 1) quotients, truncated toward zero.
    always_comb begin
        w_rem_full = r3_year - YW'(r3_q100) * YW'(100);
        w_rem100   = w_rem_full[6:0];
        w_year0    = (r3_year == '0);
        w_q4       = r3_year[YW-1:2];
        w_q400     = r3_q100[rtcf_pkg::Q100_W-1:2];
        w_leap     = ((r3_year[1:0] == 2'b00) && (w_rem100 != 7'd0))
                   || ((w_rem100 == 7'd0) && (r3_q100[1:0] == 2'b00));

        // Year zero gives -1 for (year - 1), whose quotients are all zero.
        if (w_year0) begin
            n_d4   = '0;
            n_d100 = '0;
            n_d400 = '0;
        end else begin
            n_d4   = (r3_year[1:0] == 2'b00) ? w_q4 - 1'b1 : w_q4;
            n_d100 = (w_rem100 == 7'd0) ? r3_q100 - 1'b1 : r3_q100;
            n_d400 = ((w_rem100 == 7'd0) && (r3_q100[1:0] == 2'b00))
                   ? w_q400 - 1'b1 : w_q400;
        end

        n_mday = rtcf_pkg::MDAY_W'(rtcf_pkg::cum_days(r3_month))
               + rtcf_pkg::MDAY_W'(w_leap && (r3_month > 4'd2))
               + rtcf_pkg::MDAY_W'(r3_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r4_y365 <= r3_y365;
            r4_d4   <= n_d4;
            r4_d100 <= n_d100;
            r4_d400 <= n_d400;
            r4_mday <= n_mday;
            r4_tod  <= r3_tod;
            r4_err  <= r3_err;
        end
    end

    // Stage five: sum of the terms, less the epoch day number, in two's complement.
    assign n_days = rtcf_pkg::DAYS_W'(r4_y365)
                  + rtcf_pkg::DAYS_W'(r4_d4)
                  - rtcf_pkg::DAYS_W'(r4_d100)
                  + rtcf_pkg::DAYS_W'(r4_d400)
                  + rtcf_pkg::DAYS_W'(r4_mday)
                  - rtcf_pkg::DAYS_W'(rtcf_pkg::EPOCH_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r5_days.days <= $signed(n_days);
            r5_days.tod  <= r4_tod;
            r5_days.err  <= r4_err;
        end
    end

    assign o_days = r5_days;

endmodule

>>> rtl/rtcf_total.sv
// Stages six and seven: seconds total, 32-bit wrap and the range flag.
module rtcf_total (
    input  logic            i_clk,
    input  logic [1:0]      i_adv,
    input  rtcf_pkg::t_days i_days,
    output logic [31:0]     o_epoch_seconds,
    output logic            o_range_error
);

    localparam int unsigned TW = rtcf_pkg::TOTAL_W;
    localparam int unsigned MW = rtcf_pkg::DAYS_W + 18;

    logic signed [MW-1:0] w_mul;
    logic [TW-1:0]        n_total;
    logic [TW-1:0]        r6_total;
    logic                 r6_err;
    logic [31:0]          r7_epoch;
    logic                 r7_err;

    // Stage six: days times 86400 plus the time of day.
    assign w_mul   = i_days.days * rtcf_pkg::DAY_SECS;
    assign n_total = TW'(w_mul) + TW'(i_days.tod);

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r6_total <= n_total;
            r6_err   <= i_days.err | i_days.days[rtcf_pkg::DAYS_W-1];
        end
    end

    // Stage seven: flag a clamped month, a negative day count or total, or a total that does not fit 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r7_epoch <= r6_total[31:0];
            r7_err   <= r6_err | (r6_total[TW-1:32] != '0);
        end
    end

    assign o_epoch_seconds = r7_epoch;
    assign o_range_error   = r7_err;

endmodule

>>> rtl/rtc_fields_to_epoch_seconds_top.sv
// Top level: clock register snapshot to seconds since 1970, seven-stage pipeline.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_valid / o_stall          i_raw_second .. i_raw_century
//  result    out        o_valid / i_stall          o_epoch_seconds, o_range_error
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word enters per cycle while o_stall is low; each result passes through
// the seven register stages of decode, day count and total.
// Synchronous reset empties every stage and sets BCD and 24-hour mode.
// A stalled result holds its stage; empty stages ahead of a stall still fill.

`include "rtc_fields_to_epoch_seconds_top_macros.svh"

module rtc_fields_to_epoch_seconds_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_raw_second,
    input  logic [7:0]                     i_raw_minute,
    input  logic [7:0]                     i_raw_hour,
    input  logic [7:0]                     i_raw_day,
    input  logic [7:0]                     i_raw_month,
    input  logic [7:0]                     i_raw_year,
    input  logic [7:0]                     i_raw_century,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [31:0]                    o_epoch_seconds,
    output logic                           o_range_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rtcf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);

    localparam int unsigned NS = rtcf_pkg::NUM_STAGES;

    logic                 r_bcd_mode;
    logic                 r_hour24_mode;
    logic [NS-1:0]        r_vld;
    logic [NS:0]          w_ready;
    rtcf_pkg::t_fields    w_fields;
    rtcf_pkg::t_days      w_days;

    // Mode registers; writes to an index outside the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd_mode    <= 1'b1;
            r_hour24_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rtcf_pkg::REG_BCD_MODE:    r_bcd_mode    <= i_cfg_data;
                rtcf_pkg::REG_HOUR24_MODE: r_hour24_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or the stage after it loads.
    always_comb begin
        w_ready[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
    end

    // Valid bits travel with the data through the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ready[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_ready[0];
    assign o_valid = r_vld[NS-1];

    rtcf_decode u_decode (
        .i_clk         (i_clk),
        .i_en          (w_ready[0]),
        .i_bcd_mode    (r_bcd_mode),
        .i_hour24_mode (r_hour24_mode),
        .i_raw_second  (i_raw_second),
        .i_raw_minute  (i_raw_minute),
        .i_raw_hour    (i_raw_hour),
        .i_raw_day     (i_raw_day),
        .i_raw_month   (i_raw_month),
        .i_raw_year    (i_raw_year),
        .i_raw_century (i_raw_century),
        .o_fields      (w_fields)
    );

    rtcf_days u_days (
        .i_clk    (i_clk),
        .i_adv    (w_ready[4:1]),
        .i_fields (w_fields),
        .o_days   (w_days)
    );

    rtcf_total u_total (
        .i_clk           (i_clk),
        .i_adv           (w_ready[6:5]),
        .i_days          (w_days),
        .o_epoch_seconds (o_epoch_seconds),
        .o_range_error   (o_range_error)
    );

    // An accepted word is in the first stage on the next cycle.
    `RTCF_ASSERT(a_accept_lands, i_valid && !o_stall |=> r_vld[0], "accepted word not captured")
    // A pipeline with an empty output stage never pushes back on the input.
    `RTCF_ASSERT(a_no_false_stall, !o_valid |-> !o_stall, "stall with empty output stage")
    // A blocked middle stage keeps its word.
    `RTCF_ASSERT(a_mid_hold, r_vld[3] && !w_ready[4] |=> r_vld[3], "blocked stage lost word")
    // Reset leaves both modes at their default.
    `RTCF_ASSERT_NR(a_mode_reset, !i_rst_n |=> r_bcd_mode && r_hour24_mode, "mode reset value")

endmodule
